// File: src/rcsc_pkg.sv
`timescale 1ns / 1ps
package rcsc_pkg;

  // Pipeline depth: input register is stage 1, output register is the last stage.
  localparam int NST = 13;

  localparam logic [2:0] MODE_RGB = 3'd0;
  localparam logic [2:0] MODE_YIQ = 3'd1;
  localparam logic [2:0] MODE_HSI = 3'd2;
  localparam logic [2:0] MODE_YCC = 3'd3;
  localparam logic [2:0] MODE_XYZ = 3'd4;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [8:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
  } comp_t;

  typedef logic signed [15:0] coef_mat_t [0:2][0:2];

  // Q1.15 rows, one per output component
  localparam coef_mat_t YIQ_K = '{
    '{16'sd9798,  16'sd19235,  16'sd3736},
    '{16'sd19530, -16'sd9011,  -16'sd10519},
    '{16'sd6947,  -16'sd17138, 16'sd10191}
  };

  localparam coef_mat_t YCC_K = '{
    '{16'sd9798,  16'sd19235,  16'sd3736},
    '{-16'sd5538, -16'sd10846, 16'sd16384},
    '{16'sd16384, -16'sd13730, -16'sd2654}
  };

  // D50 matrix times 100, Q16
  localparam logic [22:0] XYZ_K [0:2][0:2] = '{
    '{23'd2857711, 23'd2523671, 23'd937738},
    '{23'd1458121, 23'd4698184, 23'd397289},
    '{23'd91286,   23'd636335,  23'd4680486}
  };

  // atan(2^-i) in Q16 degrees
  localparam logic [21:0] CORDIC_ATAN [0:15] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
    22'd234379,  22'd117304,  22'd58666,  22'd29335,
    22'd14668,   22'd7334,    22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115
  };

  localparam logic [16:0] HUE_SQRT3 = 17'd113512;   // sqrt(3) in Q16

  typedef logic [15:0] lin_tab_t [0:255];

  // sRGB linearization, Q0.16, evaluated at elaboration
  function automatic lin_tab_t build_lin_table();
    lin_tab_t tab;
    longint unsigned u, u2, lo, hi, mid, r2, r4, p5, l30, q16;
    for (int v = 0; v < 256; v++) begin
      if (v <= 10) begin
        tab[v] = 16'((longint'(v) * 13107200 + 329460) / 658920);
      end else begin
        u  = ((longint'(v) * 1000 + 14025) << 30) / 269025;
        u2 = (u * u) >> 30;
        lo = 0;
        hi = longint'(1) << 30;
        for (int it = 0; it < 32; it++) begin
          if (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            r2  = (mid * mid) >> 30;
            r4  = (r2 * r2) >> 30;
            p5  = (r4 * mid) >> 30;
            if (p5 <= u2) lo = mid;
            else hi = mid - 1;
          end
        end
        l30 = (u2 * lo) >> 30;
        q16 = (l30 + (longint'(1) << 13)) >> 14;
        tab[v] = (q16 > 65535) ? 16'hFFFF : q16[15:0];
      end
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TABLE = build_lin_table();

endpackage

// File: src/rcsc_matrix.sv
`timescale 1ns / 1ps
module rcsc_matrix import rcsc_pkg::*; (
  input  logic         clk,
  input  logic [NST:1] en,
  input  pix_t         pix,
  input  logic [2:0]   mode,
  output comp_t        res
);

  coef_mat_t        kc;
  logic [7:0]       cv [0:2];
  logic signed [24:0] prod_r [0:2][0:2];
  logic signed [26:0] sum [0:2];
  logic [26:0]      mag [0:2];
  logic [7:0]       q8 [0:2];
  comp_t            res_nxt;
  comp_t            res_r [3:NST-1];

  always_comb begin
    kc = (mode == MODE_YCC) ? YCC_K : YIQ_K;
    cv[0] = pix.red;
    cv[1] = pix.green;
    cv[2] = pix.blue;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          prod_r[i][j] <= kc[i][j] * $signed({1'b0, cv[j]});
    end
  end

  // truncate toward zero, keep low byte
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = 27'(prod_r[i][0]) + 27'(prod_r[i][1]) + 27'(prod_r[i][2]);
      mag[i] = sum[i][26] ? 27'(-sum[i]) : 27'(sum[i]);
      q8[i]  = mag[i][22:15];
      if (sum[i][26]) q8[i] = -q8[i];
    end
    res_nxt.c0 = {1'b0, q8[0]};
    res_nxt.c1 = q8[1];
    res_nxt.c2 = q8[2];
  end

  always_ff @(posedge clk) begin
    if (en[3]) res_r[3] <= res_nxt;
    for (int k = 4; k <= NST - 1; k++)
      if (en[k]) res_r[k] <= res_r[k-1];
  end

  assign res = res_r[NST-1];

endmodule

// File: src/rcsc_xyz.sv
`timescale 1ns / 1ps
module rcsc_xyz import rcsc_pkg::*; (
  input  logic         clk,
  input  logic [NST:1] en,
  input  pix_t         pix,
  output comp_t        res
);

  logic [15:0] lin_r [0:2];
  logic [38:0] prod_r [0:2][0:2];
  logic [40:0] sum [0:2];
  comp_t       res_nxt;
  comp_t       res_r [4:NST-1];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      lin_r[0] <= LIN_TABLE[pix.red];
      lin_r[1] <= LIN_TABLE[pix.green];
      lin_r[2] <= LIN_TABLE[pix.blue];
    end
    if (en[3]) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          prod_r[i][j] <= 39'(XYZ_K[i][j]) * 39'(lin_r[j]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++)
      sum[i] = 41'(prod_r[i][0]) + 41'(prod_r[i][1]) + 41'(prod_r[i][2]);
    res_nxt.c0 = sum[0][40:32];
    res_nxt.c1 = sum[1][39:32];
    res_nxt.c2 = sum[2][39:32];
  end

  always_ff @(posedge clk) begin
    if (en[4]) res_r[4] <= res_nxt;
    for (int k = 5; k <= NST - 1; k++)
      if (en[k]) res_r[k] <= res_r[k-1];
  end

  assign res = res_r[NST-1];

endmodule

// File: src/rcsc_hsi.sv
`timescale 1ns / 1ps
module rcsc_hsi import rcsc_pkg::*; (
  input  logic         clk,
  input  logic [NST:1] en,
  input  pix_t         pix,
  output comp_t        res
);

  localparam logic signed [25:0] Z_90  = 26'sd5898240;
  localparam logic signed [25:0] Z_180 = 26'sd11796480;
  localparam logic [24:0]        Z_360 = 25'd23592960;

  // stage 2
  logic signed [10:0] x2;
  logic signed [8:0]  d2;
  logic signed [26:0] px2_r;
  logic [24:0]        py2_r;
  logic [9:0]         t2_r;
  logic [7:0]         mn2_r;
  logic [7:0]         mn2;
  logic               zero_r [2:11];
  logic               bgt_r  [2:11];

  // CORDIC, two rotations per stage
  logic signed [29:0] px_r [3:11];
  logic signed [29:0] py_r [3:11];
  logic signed [25:0] z_r  [3:11];
  logic signed [29:0] px_nxt [4:11];
  logic signed [29:0] py_nxt [4:11];
  logic signed [25:0] z_nxt  [4:11];
  logic signed [29:0] tx, ty, dx, dy;
  logic signed [25:0] tz;

  // saturation divider, one quotient bit per stage
  logic [16:0] rem_r [3:10];
  logic [9:0]  den_r [3:9];
  logic [6:0]  q_r   [3:12];
  logic [16:0] rem_nxt [4:10];
  logic [6:0]  q_nxt   [4:10];
  logic [16:0] dsh;

  logic [7:0]  int_r [3:12];
  logic [19:0] int_prod;

  logic signed [25:0] zc;
  logic [24:0]        hq;
  logic [8:0]         hdeg;
  logic [8:0]         hue_nxt;
  logic [8:0]         hue_r;

  always_comb begin
    x2  = $signed({2'b0, pix.red, 1'b0}) - $signed({3'b0, pix.green})
        - $signed({3'b0, pix.blue});
    d2  = $signed({1'b0, pix.green}) - $signed({1'b0, pix.blue});
    mn2 = (pix.red < pix.green) ? pix.red : pix.green;
    if (pix.blue < mn2) mn2 = pix.blue;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      px2_r     <= {x2, 16'b0};
      py2_r     <= 25'((d2[8] ? 8'(-d2) : d2[7:0])) * 25'(HUE_SQRT3);
      t2_r      <= 10'(pix.red) + 10'(pix.green) + 10'(pix.blue);
      mn2_r     <= mn2;
      zero_r[2] <= (pix.red == pix.green) && (pix.green == pix.blue);
      bgt_r[2]  <= pix.blue > pix.green;
    end
  end

  assign int_prod = 20'(t2_r) * 20'd683;   // t/3 for t < 768

  always_ff @(posedge clk) begin
    if (en[3]) begin
      if (px2_r < 0) begin
        px_r[3] <= 30'(py2_r);
        py_r[3] <= -30'(px2_r);
        z_r[3]  <= Z_90;
      end else begin
        px_r[3] <= 30'(px2_r);
        py_r[3] <= 30'(py2_r);
        z_r[3]  <= '0;
      end
      rem_r[3] <= 17'(t2_r) * 17'd100 - 17'(mn2_r) * 17'd300;
      den_r[3] <= t2_r;
      q_r[3]   <= '0;
      int_r[3] <= int_prod[18:11];
    end
  end

  always_comb begin
    tx = '0;
    ty = '0;
    tz = '0;
    dx = '0;
    dy = '0;
    for (int s = 0; s < 8; s++) begin
      tx = px_r[s+3];
      ty = py_r[s+3];
      tz = z_r[s+3];
      for (int j = 0; j < 2; j++) begin
        dx = ty >>> (2 * s + j);
        dy = tx >>> (2 * s + j);
        if (ty >= 0) begin
          tx = tx + dx;
          ty = ty - dy;
          tz = tz + $signed(26'(CORDIC_ATAN[2*s+j]));
        end else begin
          tx = tx - dx;
          ty = ty + dy;
          tz = tz - $signed(26'(CORDIC_ATAN[2*s+j]));
        end
      end
      px_nxt[s+4] = tx;
      py_nxt[s+4] = ty;
      z_nxt[s+4]  = tz;
    end
  end

  always_comb begin
    dsh = '0;
    for (int k = 4; k <= 10; k++) begin
      dsh        = 17'(den_r[k-1]) << (10 - k);
      rem_nxt[k] = rem_r[k-1];
      q_nxt[k]   = q_r[k-1];
      if (den_r[k-1] != '0 && rem_r[k-1] >= dsh) begin
        rem_nxt[k]       = rem_r[k-1] - dsh;
        q_nxt[k][10 - k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 4; k <= 11; k++)
      if (en[k]) begin
        px_r[k] <= px_nxt[k];
        py_r[k] <= py_nxt[k];
        z_r[k]  <= z_nxt[k];
      end
    for (int k = 4; k <= 10; k++)
      if (en[k]) begin
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
      end
    for (int k = 11; k <= 12; k++)
      if (en[k]) q_r[k] <= q_r[k-1];
    for (int k = 4; k <= 9; k++)
      if (en[k]) den_r[k] <= den_r[k-1];
    for (int k = 4; k <= 12; k++)
      if (en[k]) int_r[k] <= int_r[k-1];
    for (int k = 3; k <= 11; k++)
      if (en[k]) begin
        zero_r[k] <= zero_r[k-1];
        bgt_r[k]  <= bgt_r[k-1];
      end
  end

  // clamp to [0, 180] degrees, reflect when blue exceeds green
  always_comb begin
    if (z_r[11] < 0) zc = '0;
    else if (z_r[11] > Z_180) zc = Z_180;
    else zc = z_r[11];
    hq   = bgt_r[11] ? Z_360 - 25'(zc) : 25'(zc);
    hdeg = hq[24:16];
    if (zero_r[11]) hue_nxt = '0;
    else if (hdeg > 9'd359) hue_nxt = 9'd359;
    else hue_nxt = hdeg;
  end

  always_ff @(posedge clk) begin
    if (en[12]) hue_r <= hue_nxt;
  end

  assign res.c0 = hue_r;
  assign res.c1 = {1'b0, q_r[12]};
  assign res.c2 = int_r[12];

endmodule

// File: src/rgb_color_space_converter_core.sv
`timescale 1ns / 1ps
// RGB color space converter: one 8-bit RGB pixel in, three components out, in
// RGB, YIQ, HSI, YCbCr or XYZ as chosen by cfg_wr_data (write it while idle).
// Takes a pixel every clock while in_stall is low; pipeline depth is set by the
// 16-step hue CORDIC run two rotations per stage. A stall on the
// output backs up through the pipeline stage by stage; empty stages still fill.
module rgb_color_space_converter_core import rcsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [8:0] out_first_component,
  output logic [7:0] out_second_component,
  output logic [7:0] out_third_component,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data
);

  logic [2:0]     mode_r;
  logic [NST:1]   v_r;
  logic [NST+1:1] en;
  pix_t           pix_r [1:NST-1];
  logic [2:0]     md_r  [1:NST-1];
  comp_t          mat_res, xyz_res, hsi_res;
  comp_t          out_nxt, out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= MODE_RGB;
    else if (cfg_wr_en) mode_r <= cfg_wr_data;
  end

  // a stage loads when it is empty or its content moves on
  always_comb begin
    en[NST+1] = !out_stall;
    for (int k = NST; k >= 1; k--)
      en[k] = !v_r[k] || en[k+1];
  end

  assign in_stall = !en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_valid;
      for (int k = 2; k <= NST; k++)
        if (en[k]) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pix_r[1] <= {in_red, in_green, in_blue};
      md_r[1]  <= mode_r;
    end
    for (int k = 2; k <= NST - 1; k++)
      if (en[k]) begin
        pix_r[k] <= pix_r[k-1];
        md_r[k]  <= md_r[k-1];
      end
  end

  rcsc_matrix u_matrix (
    .clk  (clk),
    .en   (en[NST:1]),
    .pix  (pix_r[1]),
    .mode (md_r[1]),
    .res  (mat_res)
  );

  rcsc_xyz u_xyz (
    .clk (clk),
    .en  (en[NST:1]),
    .pix (pix_r[1]),
    .res (xyz_res)
  );

  rcsc_hsi u_hsi (
    .clk (clk),
    .en  (en[NST:1]),
    .pix (pix_r[1]),
    .res (hsi_res)
  );

  always_comb begin
    unique case (md_r[NST-1])
      MODE_YIQ, MODE_YCC: out_nxt = mat_res;
      MODE_HSI:           out_nxt = hsi_res;
      MODE_XYZ:           out_nxt = xyz_res;
      default: begin
        out_nxt.c0 = {1'b0, pix_r[NST-1].red};
        out_nxt.c1 = pix_r[NST-1].green;
        out_nxt.c2 = pix_r[NST-1].blue;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[NST]) out_r <= out_nxt;
  end

  assign out_valid            = v_r[NST];
  assign out_first_component  = out_r.c0;
  assign out_second_component = out_r.c1;
  assign out_third_component  = out_r.c2;

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v_r == '1) && out_stall)
    else $error("input stalled while pipeline has room");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (v_r == '0))
    else $error("valid bits not cleared by reset");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[6] && !en[7]) |=> v_r[6])
    else $error("blocked transaction dropped from middle stage");

  a_first_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_first_component <= 9'd359)
    else $error("first component out of range");

endmodule
